// ----- rtl/sacl_pkg.sv -----
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types and constants of the lfu set-associative byte cache
// ----------------------------------------------------------------------------
package sacl_pkg;

  // default geometry
  localparam int DEF_MAX_SET_BITS    = 4;
  localparam int DEF_MAX_OFFSET_BITS = 3;
  localparam int DEF_MAX_WAYS        = 4;
  localparam int DEF_ADDR_BITS       = 16;

  // field widths
  localparam int REQ_W     = 2;
  localparam int DATA_W    = 8;
  localparam int TAG_W     = 16;
  localparam int CNT_W     = 8;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int SETB_W    = 3;
  localparam int OFFB_W    = 2;
  localparam int WAYS_W    = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PRELOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  // one way of a set row in the tag memory
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] cnt;
  } meta_ent_t;

endpackage

// ----- rtl/sacl_ram.sv -----
// ----------------------------------------------------------------------------
// sacl_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/set_assoc_cache_lfu.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lfu
// byte cache with least-frequently-used replacement, write-through backing
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with out_valid high, which the
// receiver must take then. A preload or an unused code never raises busy; a
// write passes through the lookup state, a read hit through lookup and
// data-read states (tag row read, then data read). A read miss passes through
// lookup, then fill, where the block is filled one byte per cycle through the
// single read port of the backing memory. The result appears in the cycle
// busy drops (for a preload, the cycle after acceptance). Line valid bits are
// flip-flops cleared by reset, so there is no clearing pass after reset.
module set_assoc_cache_lfu
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS    = DEF_MAX_SET_BITS,
  parameter int MAX_OFFSET_BITS = DEF_MAX_OFFSET_BITS,
  parameter int MAX_WAYS        = DEF_MAX_WAYS,
  parameter int ADDR_BITS       = DEF_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sacl_pkg::REQ_W-1:0]    in_req_type,
  input  logic [ADDR_BITS-1:0]          in_byte_address,
  input  logic [sacl_pkg::DATA_W-1:0]   in_write_data,
  output logic                          out_valid,
  output logic [sacl_pkg::DATA_W-1:0]   out_read_data,
  output logic                          out_hit,
  input  logic                          cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sacl_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int MAX_BLOCK = 1 << MAX_OFFSET_BITS;
  localparam int NUM_LINES = NUM_SETS * MAX_WAYS;
  localparam int LB_DEPTH  = NUM_LINES * MAX_BLOCK;
  localparam int BK_DEPTH  = 1 << ADDR_BITS;
  localparam int SET_IW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int OFF_IW    = (MAX_OFFSET_BITS > 0) ? MAX_OFFSET_BITS : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LB_AW     = (LB_DEPTH > 1) ? $clog2(LB_DEPTH) : 1;
  localparam int ENT_W     = $bits(meta_ent_t);
  localparam int ROW_W     = MAX_WAYS * ENT_W;
  localparam int CMP_W     = (ADDR_BITS > TAG_W) ? ADDR_BITS : TAG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_RDATA,
    S_FILL
  } state_t;

  // configuration
  logic [SETB_W-1:0] set_bits_r;
  logic [OFFB_W-1:0] offset_bits_r;
  logic [WAYS_W-1:0] ways_r;

  // control and payload registers
  state_t                  state_r, state_nxt;
  logic [REQ_W-1:0]        req_r;
  logic [ADDR_BITS-1:0]    addr_r;
  logic [DATA_W-1:0]       data_r;
  logic [WAY_W-1:0]        way_r, way_nxt;
  logic [OFF_IW-1:0]       idx_r, idx_nxt;
  logic [DATA_W-1:0]       byte_r, byte_nxt;
  meta_ent_t [MAX_WAYS-1:0] fill_row_r, fill_row_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]       out_data_r, out_data_nxt;
  logic                    out_hit_r, out_hit_nxt;
  logic [NUM_SETS-1:0][MAX_WAYS-1:0] valid_r;

  // effective configuration
  logic [3:0]           eff_sb;
  logic [OFFB_W-1:0]    eff_ob;
  logic [4:0]           eff_nw;

  // address decode
  logic [ADDR_BITS-1:0] dec_addr;
  logic [ADDR_BITS-1:0] tag_full;
  logic [ADDR_BITS-1:0] set_full;
  logic [SET_IW-1:0]    set_mask;
  logic [SET_IW-1:0]    set_idx;
  logic [OFF_IW-1:0]    off_mask;
  logic [OFF_IW-1:0]    off;
  logic [ADDR_BITS-1:0] base;

  // lookup
  meta_ent_t [MAX_WAYS-1:0] row_q;
  meta_ent_t [MAX_WAYS-1:0] upd_row;
  logic [MAX_WAYS-1:0]  set_valid;
  logic [CNT_W-1:0]     ent_cnt [MAX_WAYS];
  logic                 hit_found;
  logic [WAY_W-1:0]     hit_way;
  logic                 inv_found;
  logic [WAY_W-1:0]     inv_way;
  logic [CNT_W-1:0]     best_cnt;
  logic [WAY_W-1:0]     min_way;
  logic [WAY_W-1:0]     way_sel;
  logic [CNT_W-1:0]     cnt_inc;

  // memory ports
  logic                 meta_we;
  logic [WAY_W-1:0]     meta_way;
  meta_ent_t [MAX_WAYS-1:0] meta_wdata;
  logic                 lb_we;
  logic [WAY_W-1:0]     lb_way;
  logic [OFF_IW-1:0]    lb_off;
  logic [LB_AW-1:0]     lb_addr;
  logic [DATA_W-1:0]    lb_wdata;
  logic [DATA_W-1:0]    lb_rdata;
  logic                 bk_we;
  logic [ADDR_BITS-1:0] bk_waddr;
  logic [DATA_W-1:0]    bk_wdata;
  logic [ADDR_BITS-1:0] bk_raddr;
  logic [DATA_W-1:0]    bk_rdata;
  logic                 accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // saturate the configuration
  always_comb begin
    eff_sb = ({1'b0, set_bits_r} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_r};
    eff_ob = ({1'b0, offset_bits_r} > 3'(MAX_OFFSET_BITS)) ?
             OFFB_W'(MAX_OFFSET_BITS) : offset_bits_r;
    if (ways_r == '0) begin
      eff_nw = 5'd1;
    end else if (5'(ways_r) > 5'(MAX_WAYS)) begin
      eff_nw = 5'(MAX_WAYS);
    end else begin
      eff_nw = 5'(ways_r);
    end
  end

  // split the address: request port while idle, held request otherwise
  always_comb begin
    dec_addr = (state_r == S_IDLE) ? in_byte_address : addr_r;
    tag_full = dec_addr >> (5'(eff_sb) + 5'(eff_ob));
    set_full = dec_addr >> eff_ob;
    set_mask = ~({SET_IW{1'b1}} << eff_sb);
    set_idx  = SET_IW'(set_full) & set_mask;
    off_mask = ~({OFF_IW{1'b1}} << eff_ob);
    off      = OFF_IW'(dec_addr) & off_mask;
    base     = dec_addr & ~ADDR_BITS'(off_mask);
  end

  // hit, invalid and least-used way search over the set row
  always_comb begin
    set_valid = valid_r[set_idx];
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      ent_cnt[w] = set_valid[w] ? row_q[w].cnt : '0;
      if (5'(w) < eff_nw) begin
        if (!hit_found && set_valid[w] && (CMP_W'(row_q[w].tag) == CMP_W'(tag_full))) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(w);
        end
        if (!inv_found && !set_valid[w]) begin
          inv_found = 1'b1;
          inv_way   = WAY_W'(w);
        end
      end
    end
    best_cnt = ent_cnt[0];
    min_way  = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if ((5'(w) < eff_nw) && (ent_cnt[w] < best_cnt)) begin
        best_cnt = ent_cnt[w];
        min_way  = WAY_W'(w);
      end
    end
    if (hit_found) begin
      way_sel = hit_way;
    end else if (inv_found) begin
      way_sel = inv_way;
    end else begin
      way_sel = min_way;
    end
    // a read miss adds one per fill byte
    cnt_inc = (req_r == REQ_READ && !hit_found) ? (CNT_W'(1) << eff_ob) : CNT_W'(1);
    upd_row = row_q;
    upd_row[way_sel].tag = TAG_W'(tag_full);
    upd_row[way_sel].cnt = ent_cnt[way_sel] + cnt_inc;
  end

  // request sequencing
  always_comb begin
    state_nxt     = state_r;
    way_nxt       = way_r;
    idx_nxt       = idx_r;
    byte_nxt      = byte_r;
    fill_row_nxt  = fill_row_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    out_hit_nxt   = out_hit_r;
    meta_we       = 1'b0;
    lb_we         = 1'b0;
    bk_we         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_PRELOAD: begin
              bk_we         = 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = in_write_data;
              out_hit_nxt   = 1'b0;
            end
            REQ_READ, REQ_WRITE: begin
              state_nxt = S_LOOK;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_hit_nxt   = 1'b0;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (req_r == REQ_WRITE) begin
          meta_we       = 1'b1;
          lb_we         = 1'b1;
          bk_we         = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_hit_nxt   = hit_found;
          state_nxt     = S_IDLE;
        end else if (hit_found) begin
          meta_we   = 1'b1;
          state_nxt = S_RDATA;
        end else begin
          fill_row_nxt = upd_row;
          way_nxt      = way_sel;
          idx_nxt      = '0;
          state_nxt    = S_FILL;
        end
      end
      S_RDATA: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = lb_rdata;
        out_hit_nxt   = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FILL: begin
        lb_we = 1'b1;
        if (idx_r == off) begin
          byte_nxt = bk_rdata;
        end
        if (idx_r == off_mask) begin
          meta_we       = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = (idx_r == off) ? bk_rdata : byte_r;
          out_hit_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // memory addressing
  always_comb begin
    meta_way   = (state_r == S_FILL) ? way_r : way_sel;
    meta_wdata = (state_r == S_FILL) ? fill_row_r : upd_row;
    lb_way     = (state_r == S_FILL) ? way_r : way_sel;
    lb_off     = (state_r == S_FILL) ? idx_r : off;
    lb_addr    = ((LB_AW'(set_idx) * LB_AW'(MAX_WAYS) + LB_AW'(lb_way)) << MAX_OFFSET_BITS)
                 | LB_AW'(lb_off);
    lb_wdata   = (state_r == S_FILL) ? bk_rdata : data_r;
    bk_waddr   = (state_r == S_IDLE) ? in_byte_address : addr_r;
    bk_wdata   = (state_r == S_IDLE) ? in_write_data : data_r;
    bk_raddr   = (state_r == S_FILL) ? (base | ADDR_BITS'(idx_r + 1'b1)) : base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      valid_r       <= '0;
      set_bits_r    <= '0;
      offset_bits_r <= '0;
      ways_r        <= WAYS_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (meta_we) begin
        valid_r[set_idx][meta_way] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_BITS:    set_bits_r    <= cfg_wdata;
          CFG_OFFSET_BITS: offset_bits_r <= OFFB_W'(cfg_wdata);
          CFG_WAYS_IN_USE: ways_r        <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
    if (accept) begin
      req_r  <= in_req_type;
      addr_r <= in_byte_address;
      data_r <= in_write_data;
    end
    way_r      <= way_nxt;
    idx_r      <= idx_nxt;
    byte_r     <= byte_nxt;
    fill_row_r <= fill_row_nxt;
    out_data_r <= out_data_nxt;
    out_hit_r  <= out_hit_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_hit       = out_hit_r;

  // tag and use count, one row per set
  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (set_idx),
    .wdata (meta_wdata),
    .raddr (set_idx),
    .rdata (row_q)
  );

  // cached bytes
  sacl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LB_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (lb_we),
    .waddr (lb_addr),
    .wdata (lb_wdata),
    .raddr (lb_addr),
    .rdata (lb_rdata)
  );

  // backing byte memory
  sacl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BK_DEPTH)
  ) u_back_ram (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

endmodule

// ----- rtl/sacl_chk.sv -----
// ----------------------------------------------------------------------------
// sacl_chk
// port-level checks of request timing and result content
// ----------------------------------------------------------------------------
module sacl_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [sacl_pkg::REQ_W-1:0]  in_req_type,
  input logic [sacl_pkg::DATA_W-1:0] in_write_data,
  input logic                        out_valid,
  input logic [sacl_pkg::DATA_W-1:0] out_read_data,
  input logic                        out_hit
);
  import sacl_pkg::*;

  logic acc;

  assign acc = start && !busy;

  // preload echoes its byte on the next cycle, never a hit
  a_preload: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req_type == REQ_PRELOAD) |=>
      out_valid && !out_hit && (out_read_data == $past(in_write_data)))
    else $error("preload result wrong");

  // unused code gives an all-zero result on the next cycle
  a_unused: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req_type == REQ_UNUSED) |=>
      out_valid && !out_hit && (out_read_data == '0))
    else $error("unused request result wrong");

  // write holds the block for its lookup state, then echoes its byte
  a_write: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req_type == REQ_WRITE) |=>
      busy ##1 (out_valid && !busy && (out_read_data == $past(in_write_data, 2))))
    else $error("write result timing or data wrong");

  // a read always needs the lookup cycle first
  a_read: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req_type == REQ_READ) |=> busy && !out_valid)
    else $error("read result too early");

  // a result only comes out once the block is free
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

endmodule

bind set_assoc_cache_lfu sacl_chk u_sacl_chk (.*);
